FILE: sv/bba_pkg.sv
`default_nettype none
package bba_pkg;

    localparam int MAX_GROUPS_DEF      = 8;
    localparam int WORDS_PER_GROUP_DEF = 128;

    // widths of the clamped group and word counts (hold 64 and 1024)
    localparam int EG_W = 7;
    localparam int EW_W = 11;

    localparam int BLK_W = 17;
    localparam int CNT_W = 14;

    // input kinds
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_LOADW  = 2'd2;
    localparam logic [1:0] OP_LOADC  = 2'd3;

    // result status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_GROUPS = 2'd0;
    localparam logic [1:0] CFG_BPG    = 2'd1;
    localparam logic [1:0] CFG_WORDS  = 2'd2;

    typedef struct packed {
        logic       found;
        logic [5:0] idx;
    } t_ffs;

endpackage
`default_nettype wire

FILE: sv/bba_bitmap_ram.sv
`default_nettype none
module bba_bitmap_ram #(
    parameter int AW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [63:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [63:0]   o_rdata
);

    logic [63:0] r_mem [1<<AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: sv/bba_ffs.sv
`default_nettype none
module bba_ffs (
    input  wire logic [63:0] i_v,
    output bba_pkg::t_ffs    o_res
);

    logic [7:0] byte_nz;
    logic [2:0] byte_sel;
    logic [2:0] bit_sel;
    logic [7:0] sel_byte;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            byte_nz[i] = |i_v[i*8 +: 8];
        end
        byte_sel = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (byte_nz[i]) begin
                byte_sel = 3'(i);
            end
        end
        sel_byte = i_v[{byte_sel, 3'b000} +: 8];
        bit_sel = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (sel_byte[i]) begin
                bit_sel = 3'(i);
            end
        end
        o_res.found = |byte_nz;
        o_res.idx   = {byte_sel, bit_sel};
    end

endmodule
`default_nettype wire

FILE: sv/block_bitmap_allocator.sv
`default_nettype none
// channel  | dir | tdata (low bit up)                                     | tuser
// s        | in  | block_number 17, group_index 3, word_index 7,          | op 2
//          |     | word_value 64, free_count 14, zero fill to 112         |
// m        | out | allocated_block 17, zero fill to 24                    | status 2
// cfg      | in  | write enable, index 2, data 14                         | -
// loads are handled in the idle state; free finds the group by repeated subtract, one subtract
// a cycle, then does a read-modify-write of the bitmap word
// allocate skips empty groups in turn, then reads and checks each scanned word in turn,
// paced by the single registered read port of the bitmap ram
// after reset the ram is cleared one word a cycle: MAX_GROUPS rounded up to a power
// of two (at least 2) times WORDS_PER_GROUP rounded up, 1024 words by default; no transfer meanwhile
// a waiting result does not block the next transfer once it is taken in the same cycle
module block_bitmap_allocator #(
    parameter int MAX_GROUPS      = bba_pkg::MAX_GROUPS_DEF,
    parameter int WORDS_PER_GROUP = bba_pkg::WORDS_PER_GROUP_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [111:0] i_s_tdata,  // block_number, group_index, word_index, word_value, free_count
    input  wire logic [1:0]   i_s_tuser,  // op
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [23:0]       o_m_tdata,  // allocated_block
    output logic [1:0]        o_m_tuser,  // status
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [13:0]  i_cfg_data
);

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int WW = $clog2(WORDS_PER_GROUP);
    localparam int AW = GW + WW;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_AG   = 3'd2;
    localparam logic [2:0] S_AR   = 3'd3;
    localparam logic [2:0] S_AC   = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FR   = 3'd6;
    localparam logic [2:0] S_FW   = 3'd7;

    logic [2:0]  r_state;
    logic [AW-1:0] r_clr;
    logic [3:0]  r_cfg_groups;
    logic [13:0] r_cfg_bpg;
    logic [7:0]  r_cfg_words;
    logic [bba_pkg::EG_W-1:0] r_g;
    logic [WW-1:0] r_w;
    logic [5:0]  r_bit;
    logic [bba_pkg::BLK_W-1:0] r_base;
    logic [bba_pkg::BLK_W-1:0] r_rem;
    logic [bba_pkg::CNT_W-1:0] r_cnt [MAX_GROUPS];
    logic        r_m_valid;
    logic [1:0]  r_m_status;
    logic [bba_pkg::BLK_W-1:0] r_m_blk;

    logic [16:0] in_blk;
    logic [2:0]  in_gi;
    logic [6:0]  in_wi;
    logic [63:0] in_wv;
    logic [13:0] in_fc;
    logic        s_acc;
    logic        loadw_ok;
    logic        loadc_ok;

    logic [bba_pkg::EG_W-1:0] eff_g;
    logic [bba_pkg::EW_W-1:0] eff_w;
    logic [GW-1:0] g_idx;
    logic        g_last;
    logic        w_last;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [63:0]   ram_rdata;
    logic [63:0]   freebits;
    bba_pkg::t_ffs ffs;

    assign in_blk = i_s_tdata[16:0];
    assign in_gi  = i_s_tdata[19:17];
    assign in_wi  = i_s_tdata[26:20];
    assign in_wv  = i_s_tdata[90:27];
    assign in_fc  = i_s_tdata[104:91];

    assign o_s_tready = (r_state == S_IDLE) && (!r_m_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign loadw_ok   = (32'(in_gi) < MAX_GROUPS) && (32'(in_wi) < WORDS_PER_GROUP);
    assign loadc_ok   = 32'(in_gi) < MAX_GROUPS;

    assign eff_g = (32'(r_cfg_groups) > MAX_GROUPS) ? bba_pkg::EG_W'(MAX_GROUPS)
                                                     : bba_pkg::EG_W'(r_cfg_groups);
    assign eff_w = (32'(r_cfg_words) > WORDS_PER_GROUP) ? bba_pkg::EW_W'(WORDS_PER_GROUP)
                                                          : bba_pkg::EW_W'(r_cfg_words);
    assign g_idx  = r_g[GW-1:0];
    assign g_last = (r_g + 1'b1) >= eff_g;
    assign w_last = (bba_pkg::EW_W'(r_w) + 1'b1) >= eff_w;

    // reserved block: bit 0 of the first word of the first group
    assign freebits = ~ram_rdata & ((r_g == '0 && r_w == '0) ? ~64'd1 : ~64'd0);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {g_idx, r_w};
        ram_wdata = ram_rdata | (64'd1 << ffs.idx);
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_we    = s_acc && (i_s_tuser == bba_pkg::OP_LOADW) && loadw_ok;
                ram_waddr = {GW'(in_gi), WW'(in_wi)};
                ram_wdata = in_wv;
            end
            S_AC: begin
                ram_we = ffs.found;
            end
            S_FW: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(64'd1 << r_bit);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bba_bitmap_ram #(.AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr ({g_idx, r_w}),
        .o_rdata (ram_rdata)
    );

    bba_ffs u_ffs (
        .i_v   (freebits),
        .o_res (ffs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_groups <= 4'd1;
            r_cfg_bpg    <= 14'd8192;
            r_cfg_words  <= 8'd128;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bba_pkg::CFG_GROUPS: r_cfg_groups <= i_cfg_data[3:0];
                bba_pkg::CFG_BPG:    r_cfg_bpg    <= i_cfg_data;
                bba_pkg::CFG_WORDS:  r_cfg_words  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
            r_g       <= '0;
            r_w       <= '0;
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_g    <= '0;
                        r_w    <= '0;
                        r_base <= '0;
                        r_rem  <= in_blk - 1'b1;
                        case (i_s_tuser)
                            bba_pkg::OP_ALLOC: r_state <= S_AG;
                            bba_pkg::OP_FREE: begin
                                if (in_blk == '0 || r_cfg_bpg == '0) begin
                                    r_m_valid  <= 1'b1;
                                    r_m_status <= bba_pkg::ST_RANGE;
                                    r_m_blk    <= '0;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            bba_pkg::OP_LOADC: begin
                                if (loadc_ok) begin
                                    r_cnt[GW'(in_gi)] <= in_fc;
                                end
                                r_m_valid  <= 1'b1;
                                r_m_status <= bba_pkg::ST_OK;
                                r_m_blk    <= '0;
                            end
                            default: begin
                                r_m_valid  <= 1'b1;
                                r_m_status <= bba_pkg::ST_OK;
                                r_m_blk    <= '0;
                            end
                        endcase
                    end
                end
                S_AG: begin
                    if (r_g >= eff_g) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= bba_pkg::ST_NOFREE;
                        r_m_blk    <= '0;
                        r_state    <= S_IDLE;
                    end else if (r_cnt[g_idx] != '0 && eff_w != '0) begin
                        r_w     <= '0;
                        r_state <= S_AR;
                    end else begin
                        r_g    <= r_g + 1'b1;
                        r_base <= r_base + bba_pkg::BLK_W'(r_cfg_bpg);
                    end
                end
                S_AR: begin
                    r_state <= S_AC;
                end
                S_AC: begin
                    if (ffs.found) begin
                        r_cnt[g_idx] <= r_cnt[g_idx] - 1'b1;
                        r_m_valid  <= 1'b1;
                        r_m_status <= bba_pkg::ST_OK;
                        r_m_blk    <= r_base + bba_pkg::BLK_W'({r_w, ffs.idx}) + 1'b1;
                        r_state    <= S_IDLE;
                    end else if (w_last) begin
                        r_g     <= r_g + 1'b1;
                        r_base  <= r_base + bba_pkg::BLK_W'(r_cfg_bpg);
                        r_state <= S_AG;
                    end else begin
                        r_w     <= r_w + 1'b1;
                        r_state <= S_AR;
                    end
                end
                S_DIV: begin
                    // repeated subtract finds group and offset within it
                    if (r_rem < bba_pkg::BLK_W'(r_cfg_bpg)) begin
                        if (r_g < eff_g && bba_pkg::EW_W'(r_rem[16:6]) < eff_w) begin
                            r_w     <= r_rem[WW+5:6];
                            r_bit   <= r_rem[5:0];
                            r_state <= S_FR;
                        end else begin
                            r_m_valid  <= 1'b1;
                            r_m_status <= bba_pkg::ST_RANGE;
                            r_m_blk    <= '0;
                            r_state    <= S_IDLE;
                        end
                    end else if (g_last) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= bba_pkg::ST_RANGE;
                        r_m_blk    <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_rem <= r_rem - bba_pkg::BLK_W'(r_cfg_bpg);
                        r_g   <= r_g + 1'b1;
                    end
                end
                S_FR: begin
                    r_state <= S_FW;
                end
                S_FW: begin
                    r_m_valid  <= 1'b1;
                    r_m_status <= bba_pkg::ST_OK;
                    r_m_blk    <= '0;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = {7'd0, r_m_blk};

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_s_tready)
        else $error("transfer accepted during ram clear");

    a_found_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AC && ffs.found) |=> (o_m_tvalid && o_m_tuser == bba_pkg::ST_OK))
        else $error("allocation hit without result");

    a_fail_zero_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != bba_pkg::ST_OK) |-> (o_m_tdata == '0))
        else $error("nonzero block on failed result");

    a_busy_no_result_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AR || r_state == S_DIV || r_state == S_FR) |-> !o_m_tvalid)
        else $error("result pending while working on an item");
`endif

endmodule
`default_nettype wire
